### rtl/tdp_pkg.sv
// shared constants and types for the trial division prime test unit
package tdp_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int CNT_W      = $clog2(DATA_WIDTH);

  typedef logic [DATA_WIDTH-1:0] tdp_word_t;

  typedef enum logic [5:0] {
    ST_IDLE     = 6'b000001,
    ST_CLASSIFY = 6'b000010,
    ST_TEST     = 6'b000100,
    ST_DIVIDE   = 6'b001000,
    ST_CHECK    = 6'b010000,
    ST_RESULT   = 6'b100000
  } tdp_state_t;

  typedef struct packed {
    logic load;       // take a new value and form its magnitude
    logic start_div;  // set up the divider for the current divisor
    logic step;       // one restoring division step
    logic advance;    // keep the quotient, move on to the next odd divisor
  } tdp_cmd_t;

  typedef struct packed {
    logic mag_le1;
    logic mag_le3;
    logic mag_even;
    logic div_gt_quo;
    logic div_last;
    logic rem_zero;
  } tdp_sts_t;

endpackage

### rtl/tdp_if.sv
// stream interfaces for the input values and the prime results
interface tdp_in_if;
  import tdp_pkg::*;
  logic      valid;
  logic      ready;
  tdp_word_t value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface tdp_out_if;
  logic valid;
  logic ready;
  logic is_prime;

  modport source (output valid, output is_prime, input ready);
  modport sink   (input valid, input is_prime, output ready);
endinterface

### rtl/tdp_datapath.sv
// datapath: magnitude, odd divisor, quotient bound and restoring divider
module tdp_datapath (
  input  logic              clk,
  input  tdp_pkg::tdp_word_t in_value,
  input  tdp_pkg::tdp_cmd_t  cmd,
  output tdp_pkg::tdp_sts_t  sts
);
  import tdp_pkg::*;

  tdp_word_t         mag_r, mag_nxt;
  tdp_word_t         div_r, div_nxt;
  tdp_word_t         quo_r, quo_nxt;
  tdp_word_t         dvd_r, dvd_nxt;
  tdp_word_t         rem_r, rem_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;

  tdp_word_t         neg;
  tdp_word_t         mag_in;
  logic [DATA_WIDTH:0] trial;

  always_comb begin
    neg = tdp_word_t'(~in_value + 1'b1);
    // zero and the most negative value both map to zero, which is not prime
    if (neg == in_value) begin
      mag_in = '0;
    end else if (in_value[DATA_WIDTH-1]) begin
      mag_in = neg;
    end else begin
      mag_in = in_value;
    end
  end

  assign trial = {rem_r, dvd_r[DATA_WIDTH-1]} - {1'b0, div_r};

  always_comb begin
    mag_nxt = mag_r;
    div_nxt = div_r;
    quo_nxt = quo_r;
    dvd_nxt = dvd_r;
    rem_nxt = rem_r;
    cnt_nxt = cnt_r;
    if (cmd.load) begin
      mag_nxt = mag_in;
      div_nxt = tdp_word_t'(3);
      quo_nxt = mag_in;
    end
    if (cmd.start_div) begin
      rem_nxt = '0;
      dvd_nxt = mag_r;
      cnt_nxt = CNT_W'(DATA_WIDTH - 1);
    end
    if (cmd.step) begin
      // borrow clear means the divisor fits: quotient bit one
      if (!trial[DATA_WIDTH]) begin
        rem_nxt = trial[DATA_WIDTH-1:0];
        dvd_nxt = {dvd_r[DATA_WIDTH-2:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[DATA_WIDTH-2:0], dvd_r[DATA_WIDTH-1]};
        dvd_nxt = {dvd_r[DATA_WIDTH-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
    end
    if (cmd.advance) begin
      quo_nxt = dvd_r;
      div_nxt = div_r + tdp_word_t'(2);
    end
  end

  always_ff @(posedge clk) begin
    mag_r <= mag_nxt;
    div_r <= div_nxt;
    quo_r <= quo_nxt;
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    cnt_r <= cnt_nxt;
  end

  assign sts.mag_le1    = (mag_r <= tdp_word_t'(1));
  assign sts.mag_le3    = (mag_r <= tdp_word_t'(3));
  assign sts.mag_even   = ~mag_r[0];
  assign sts.div_gt_quo = (div_r > quo_r);
  assign sts.div_last   = (cnt_r == '0);
  assign sts.rem_zero   = (rem_r == '0);

endmodule

### rtl/tdp_ctrl.sv
// controller: sequences the trial divisions and holds the result register
module tdp_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_is_prime,
  output tdp_pkg::tdp_cmd_t  cmd,
  input  tdp_pkg::tdp_sts_t  sts
);
  import tdp_pkg::*;

  tdp_state_t state_r, state_nxt;
  logic       res_r, res_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       is_prime_r, is_prime_nxt;

  assign in_ready     = (state_r == ST_IDLE);
  assign out_valid    = out_valid_r;
  assign out_is_prime = is_prime_r;

  always_comb begin
    state_nxt     = state_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && !out_ready;
    is_prime_nxt  = is_prime_r;
    cmd           = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_CLASSIFY;
        end
      end
      ST_CLASSIFY: begin
        if (sts.mag_le1) begin
          res_nxt   = 1'b0;
          state_nxt = ST_RESULT;
        end else if (sts.mag_le3) begin
          res_nxt   = 1'b1;
          state_nxt = ST_RESULT;
        end else if (sts.mag_even) begin
          res_nxt   = 1'b0;
          state_nxt = ST_RESULT;
        end else begin
          state_nxt = ST_TEST;
        end
      end
      ST_TEST: begin
        // divisor past the last quotient: no factor left to find
        if (sts.div_gt_quo) begin
          res_nxt   = 1'b1;
          state_nxt = ST_RESULT;
        end else begin
          cmd.start_div = 1'b1;
          state_nxt     = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        cmd.step = 1'b1;
        if (sts.div_last) begin
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (sts.rem_zero) begin
          res_nxt   = 1'b0;
          state_nxt = ST_RESULT;
        end else begin
          cmd.advance = 1'b1;
          state_nxt   = ST_TEST;
        end
      end
      ST_RESULT: begin
        // wait for the output register to be free
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          is_prime_nxt  = res_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    res_r      <= res_nxt;
    is_prime_r <= is_prime_nxt;
  end

endmodule

### rtl/trial_division_prime_test_unit.sv
// top level of the trial division prime test unit
//
// in_if carries one signed value per transfer (valid/ready); out_if returns one
// is_prime bit per value, in the same order. The magnitude of the value is
// tested; zero and the most negative value give 0.
// One value is worked on at a time. After the input transfer the block
// classifies the magnitude; values up to 3 and even values go straight
// from the classify state to the result state and the output register.
// Odd values go through trial divisors 3, 5, 7 and so on, each costing
// one bound check, DATA_WIDTH steps of a one-bit-per-cycle restoring
// divider and one remainder check. A prime near 2^31 needs about 23170
// divisors; a value with a small factor finishes after few divisors.
// Most of the run time goes to the divider steps.
// The result sits in an output register, so a new value is accepted while
// the previous result waits for out_if.ready; if the receiver stalls with
// a result still pending, the next finished result waits in its final state.
// Synchronous active-low reset returns the controller to idle and empties
// the output register; no clearing pass is needed.
module trial_division_prime_test_unit (
  input logic        clk,
  input logic        rst_n,
  tdp_in_if.sink     in_if,
  tdp_out_if.source  out_if
);
  import tdp_pkg::*;

  tdp_cmd_t cmd;
  tdp_sts_t sts;

  tdp_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_if.valid),
    .in_ready     (in_if.ready),
    .out_valid    (out_if.valid),
    .out_ready    (out_if.ready),
    .out_is_prime (out_if.is_prime),
    .cmd          (cmd),
    .sts          (sts)
  );

  tdp_datapath u_datapath (
    .clk      (clk),
    .in_value (in_if.value),
    .cmd      (cmd),
    .sts      (sts)
  );

endmodule
